>>> src/twbf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// twbf_pkg
// Shared types, constants and microcode fields for the two-wire byte write
// framer.
// ----------------------------------------------------------------------------
package twbf_pkg;

  localparam int BITS_PER_WORD = 8;
  localparam int BIT_CNT_W     = (BITS_PER_WORD > 1) ? $clog2(BITS_PER_WORD) : 1;
  localparam int DATA_W        = 8;
  localparam int WAIT_W        = 4;
  localparam int CFG_IDX_W     = 2;
  localparam int PC_W          = 4;

  typedef logic [PC_W-1:0]      pc_t;
  typedef logic [WAIT_W-1:0]    wait_t;
  typedef logic [BIT_CNT_W-1:0] bit_cnt_t;

  // Program entry points and the final step of the microcode.
  localparam pc_t PC_START = 4'd0;
  localparam pc_t PC_BIT   = 4'd3;
  localparam pc_t PC_LAST  = 4'd12;

  localparam bit_cnt_t BIT_CNT_LAST = BIT_CNT_W'(BITS_PER_WORD - 1);

  localparam wait_t BIT_PHASE_RESET = 4'd3;
  localparam wait_t EDGE_RESET      = 4'd2;
  localparam wait_t ACK_LOW_RESET   = 4'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BIT_PHASE = 2'd0,
    REG_EDGE      = 2'd1,
    REG_ACK_LOW   = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    PIN_CLK = 1'b0,
    PIN_DIO = 1'b1
  } pin_e;

  typedef enum logic [1:0] {
    LVL_ZERO = 2'd0,
    LVL_ONE  = 2'd1,
    LVL_DATA = 2'd2
  } lvl_src_e;

  typedef enum logic [1:0] {
    WAIT_ZERO  = 2'd0,
    WAIT_PHASE = 2'd1,
    WAIT_EDGE  = 2'd2,
    WAIT_ACK   = 2'd3
  } wait_src_e;

  typedef enum logic [1:0] {
    OP_NEXT       = 2'd0,
    OP_BIT_LOOP   = 2'd1,
    OP_END_NOSTOP = 2'd2,
    OP_END        = 2'd3
  } seq_op_e;

  typedef enum logic {
    SEQ_IDLE = 1'b0,
    SEQ_RUN  = 1'b1
  } seq_state_e;

  // One microcode word.
  typedef struct packed {
    pin_e      pin;
    lvl_src_e  level_src;
    wait_src_e wait_src;
    seq_op_e   op;
  } ctrl_t;

  // Per-cycle strobes from the sequencer to the datapath and output stage.
  typedef struct packed {
    logic load;
    logic shift;
    logic fire;
    logic last;
  } step_t;

  // Datapath status seen by the sequencer.
  typedef struct packed {
    logic stop;
  } dp_status_t;

  // Fields of one pin write as formed by the datapath.
  typedef struct packed {
    logic  pin;
    logic  level;
    wait_t wait_us;
  } pin_write_t;

endpackage
`default_nettype wire

>>> src/twbf_ucode_rom.sv
`default_nettype none
// ----------------------------------------------------------------------------
// twbf_ucode_rom
// Read-only control store: one control word per program step.
// ----------------------------------------------------------------------------
module twbf_ucode_rom (
  input  twbf_pkg::pc_t   pc,
  output twbf_pkg::ctrl_t ctrl
);

  always_comb begin
    case (pc)
      // Start condition.
      4'd0:  ctrl = '{twbf_pkg::PIN_DIO, twbf_pkg::LVL_ONE,  twbf_pkg::WAIT_ZERO,
                      twbf_pkg::OP_NEXT};
      4'd1:  ctrl = '{twbf_pkg::PIN_CLK, twbf_pkg::LVL_ONE,  twbf_pkg::WAIT_EDGE,
                      twbf_pkg::OP_NEXT};
      4'd2:  ctrl = '{twbf_pkg::PIN_DIO, twbf_pkg::LVL_ZERO, twbf_pkg::WAIT_EDGE,
                      twbf_pkg::OP_NEXT};
      // Data bit loop.
      4'd3:  ctrl = '{twbf_pkg::PIN_CLK, twbf_pkg::LVL_ZERO, twbf_pkg::WAIT_ZERO,
                      twbf_pkg::OP_NEXT};
      4'd4:  ctrl = '{twbf_pkg::PIN_DIO, twbf_pkg::LVL_DATA, twbf_pkg::WAIT_PHASE,
                      twbf_pkg::OP_NEXT};
      4'd5:  ctrl = '{twbf_pkg::PIN_CLK, twbf_pkg::LVL_ONE,  twbf_pkg::WAIT_PHASE,
                      twbf_pkg::OP_BIT_LOOP};
      // Acknowledge clock pulse.
      4'd6:  ctrl = '{twbf_pkg::PIN_CLK, twbf_pkg::LVL_ZERO, twbf_pkg::WAIT_ACK,
                      twbf_pkg::OP_NEXT};
      4'd7:  ctrl = '{twbf_pkg::PIN_CLK, twbf_pkg::LVL_ONE,  twbf_pkg::WAIT_EDGE,
                      twbf_pkg::OP_NEXT};
      4'd8:  ctrl = '{twbf_pkg::PIN_CLK, twbf_pkg::LVL_ZERO, twbf_pkg::WAIT_ZERO,
                      twbf_pkg::OP_END_NOSTOP};
      // Stop condition.
      4'd9:  ctrl = '{twbf_pkg::PIN_CLK, twbf_pkg::LVL_ZERO, twbf_pkg::WAIT_EDGE,
                      twbf_pkg::OP_NEXT};
      4'd10: ctrl = '{twbf_pkg::PIN_DIO, twbf_pkg::LVL_ZERO, twbf_pkg::WAIT_EDGE,
                      twbf_pkg::OP_NEXT};
      4'd11: ctrl = '{twbf_pkg::PIN_CLK, twbf_pkg::LVL_ONE,  twbf_pkg::WAIT_EDGE,
                      twbf_pkg::OP_NEXT};
      4'd12: ctrl = '{twbf_pkg::PIN_DIO, twbf_pkg::LVL_ONE,  twbf_pkg::WAIT_ZERO,
                      twbf_pkg::OP_END};
      default: ctrl = '{twbf_pkg::PIN_CLK, twbf_pkg::LVL_ZERO, twbf_pkg::WAIT_ZERO,
                        twbf_pkg::OP_END};
    endcase
  end

endmodule
`default_nettype wire

>>> src/twbf_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// twbf_sequencer
// Step counter, bit loop counter and jump logic that walk the control store.
// ----------------------------------------------------------------------------
module twbf_sequencer (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  start_cond,
  input  logic                  slot_free,
  input  twbf_pkg::dp_status_t  status,
  input  twbf_pkg::ctrl_t       ctrl,
  output twbf_pkg::pc_t         pc,
  output twbf_pkg::step_t       step,
  output logic                  busy
);

  twbf_pkg::seq_state_e state_r, state_nxt;
  twbf_pkg::pc_t        pc_r, pc_nxt;
  twbf_pkg::bit_cnt_t   bit_cnt_r, bit_cnt_nxt;
  logic                 bit_done;

  assign pc       = pc_r;
  assign busy     = (state_r == twbf_pkg::SEQ_RUN);
  assign bit_done = (bit_cnt_r == twbf_pkg::BIT_CNT_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= twbf_pkg::SEQ_IDLE;
      pc_r      <= twbf_pkg::PC_START;
      bit_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      pc_r      <= pc_nxt;
      bit_cnt_r <= bit_cnt_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    pc_nxt      = pc_r;
    bit_cnt_nxt = bit_cnt_r;
    step.load   = start;
    step.fire   = (state_r == twbf_pkg::SEQ_RUN) && slot_free;
    step.shift  = 1'b0;
    step.last   = 1'b0;

    case (ctrl.op)
      twbf_pkg::OP_NEXT:       step.last = 1'b0;
      twbf_pkg::OP_BIT_LOOP:   step.last = 1'b0;
      twbf_pkg::OP_END_NOSTOP: step.last = !status.stop;
      twbf_pkg::OP_END:        step.last = 1'b1;
      default:                 step.last = 1'b1;
    endcase

    case (state_r)
      twbf_pkg::SEQ_IDLE: begin
        if (start) begin
          state_nxt   = twbf_pkg::SEQ_RUN;
          pc_nxt      = start_cond ? twbf_pkg::PC_START : twbf_pkg::PC_BIT;
          bit_cnt_nxt = '0;
        end
      end
      twbf_pkg::SEQ_RUN: begin
        if (step.fire) begin
          if (step.last) begin
            state_nxt = twbf_pkg::SEQ_IDLE;
          end else if ((ctrl.op == twbf_pkg::OP_BIT_LOOP) && !bit_done) begin
            // Another data bit: go back to the top of the bit loop.
            step.shift  = 1'b1;
            pc_nxt      = twbf_pkg::PC_BIT;
            bit_cnt_nxt = bit_cnt_r + 1'b1;
          end else begin
            pc_nxt = pc_r + 1'b1;
          end
        end
      end
      default: state_nxt = twbf_pkg::SEQ_IDLE;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_pc_in_program: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == twbf_pkg::SEQ_RUN) |-> (pc_r <= twbf_pkg::PC_LAST))
    else $error("step counter left the program");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (step.fire && step.last) |=> (state_r == twbf_pkg::SEQ_IDLE))
    else $error("sequencer kept running after the final pin write");

  a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> ((state_r == twbf_pkg::SEQ_RUN) && (bit_cnt_r == '0)))
    else $error("accepted transaction did not start the program cleanly");

  a_cnt_before_bits: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == twbf_pkg::SEQ_RUN) && (pc_r < twbf_pkg::PC_BIT)) |-> (bit_cnt_r == '0))
    else $error("bit counter moved during the start condition");
`endif

endmodule
`default_nettype wire

>>> src/twbf_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// twbf_datapath
// Wait registers, data shift register and stop flag; forms each pin write
// from the current control word.
// ----------------------------------------------------------------------------
module twbf_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [twbf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [twbf_pkg::WAIT_W-1:0]       cfg_data,
  input  logic [twbf_pkg::DATA_W-1:0]       load_data,
  input  logic                              load_stop,
  input  twbf_pkg::step_t                   step,
  input  twbf_pkg::ctrl_t                   ctrl,
  output twbf_pkg::dp_status_t              status,
  output twbf_pkg::pin_write_t              pin_write
);

  twbf_pkg::wait_t bit_phase_r, edge_r, ack_low_r;
  logic [twbf_pkg::DATA_W-1:0] shift_r;
  logic                        stop_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_phase_r <= twbf_pkg::BIT_PHASE_RESET;
      edge_r      <= twbf_pkg::EDGE_RESET;
      ack_low_r   <= twbf_pkg::ACK_LOW_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        twbf_pkg::REG_BIT_PHASE: bit_phase_r <= cfg_data;
        twbf_pkg::REG_EDGE:      edge_r      <= cfg_data;
        twbf_pkg::REG_ACK_LOW:   ack_low_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Zeros shift in from the top, so bits beyond the byte go out as 0.
  always_ff @(posedge clk) begin
    if (step.load) begin
      shift_r <= load_data;
      stop_r  <= load_stop;
    end else if (step.shift) begin
      shift_r <= {1'b0, shift_r[twbf_pkg::DATA_W-1:1]};
    end
  end

  assign status.stop   = stop_r;
  assign pin_write.pin = ctrl.pin;

  always_comb begin
    case (ctrl.level_src)
      twbf_pkg::LVL_ZERO: pin_write.level = 1'b0;
      twbf_pkg::LVL_ONE:  pin_write.level = 1'b1;
      twbf_pkg::LVL_DATA: pin_write.level = shift_r[0];
      default:            pin_write.level = 1'b0;
    endcase
    case (ctrl.wait_src)
      twbf_pkg::WAIT_ZERO:  pin_write.wait_us = '0;
      twbf_pkg::WAIT_PHASE: pin_write.wait_us = bit_phase_r;
      twbf_pkg::WAIT_EDGE:  pin_write.wait_us = edge_r;
      twbf_pkg::WAIT_ACK:   pin_write.wait_us = ack_low_r;
      default:              pin_write.wait_us = '0;
    endcase
  end

endmodule
`default_nettype wire

>>> src/two_wire_byte_write_framer_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// two_wire_byte_write_framer_unit
// Turns one byte-write request into the run of clock and data pin writes
// of a two-wire serial bus, each paired with its hold time.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake            Payload
//   in_      sink       in_valid / in_stall  data_byte, with_start, with_stop
//   out_     source     out_valid/out_stall  pin_select, level, wait_us, last
//   cfg_     sink       cfg_we               cfg_index, cfg_data
//
// Each request becomes a run of pin writes: 27 writes for a bare byte, 30
// with a start, 31 with a stop and 34 with both. The sequencer issues one
// control word per cycle into the single output register while the output
// does not stall; a stall on the output freezes the step counter in place.
// Reset (synchronous, active low) idles the sequencer, empties the output
// register and loads the three wait registers with 3, 2 and 5.
//
// The request is accepted only while the sequencer is idle; the next one
// can be taken while the final pin write of the previous one still waits
// in the output register.
// ----------------------------------------------------------------------------
module two_wire_byte_write_framer_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  // Request channel.
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [twbf_pkg::DATA_W-1:0]     in_data_byte,
  input  logic                            in_with_start,
  input  logic                            in_with_stop,
  // Pin write channel.
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_pin_select,
  output logic                            out_level,
  output logic [twbf_pkg::WAIT_W-1:0]     out_wait_us,
  output logic                            out_last,
  // Configuration writes.
  input  logic                            cfg_we,
  input  logic [twbf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [twbf_pkg::WAIT_W-1:0]     cfg_data
);

  twbf_pkg::pc_t        pc;
  twbf_pkg::ctrl_t      ctrl;
  twbf_pkg::step_t      step;
  twbf_pkg::dp_status_t status;
  twbf_pkg::pin_write_t pin_write;
  logic                 busy;
  logic                 in_accept;
  logic                 slot_free;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_pin_r;
  logic                 out_level_r;
  twbf_pkg::wait_t      out_wait_r;
  logic                 out_last_r;

  // The input side only waits on the sequencer, never on the output.
  assign in_stall  = busy;
  assign in_accept = in_valid && !busy;

  // The output register can take a new pin write when it is empty or
  // its current transaction completes this cycle.
  assign slot_free = !out_valid_r || !out_stall;

  twbf_ucode_rom u_rom (
    .pc   (pc),
    .ctrl (ctrl)
  );

  twbf_sequencer u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (in_accept),
    .start_cond (in_with_start),
    .slot_free  (slot_free),
    .status     (status),
    .ctrl       (ctrl),
    .pc         (pc),
    .step       (step),
    .busy       (busy)
  );

  twbf_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .load_data (in_data_byte),
    .load_stop (in_with_stop),
    .step      (step),
    .ctrl      (ctrl),
    .status    (status),
    .pin_write (pin_write)
  );

  always_comb begin
    if (step.fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload holds whenever no new pin write is issued.
  always_ff @(posedge clk) begin
    if (step.fire) begin
      out_pin_r   <= pin_write.pin;
      out_level_r <= pin_write.level;
      out_wait_r  <= pin_write.wait_us;
      out_last_r  <= step.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pin_select = out_pin_r;
  assign out_level      = out_level_r;
  assign out_wait_us    = out_wait_r;
  assign out_last       = out_last_r;

endmodule
`default_nettype wire

>>> tb/two_wire_byte_write_framer_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_wire_byte_write_framer_unit_test
// Self-checking bench for the two-wire byte write framer. Byte-write requests
// go in under random gaps and the pin writes come out under random stalls.
// Every pin write is compared field by field with a local model of the
// framing sequence. A short table of edge cases runs first. A few of its rows
// also carry a hand-typed frame length and final pin write. Random requests
// follow under several wait register settings, the extremes among them.
// ----------------------------------------------------------------------------
module two_wire_byte_write_framer_unit_test;

  // Index past the end of the register list; the block must ignore it.
  localparam logic [twbf_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int NUM_SETTINGS   = 6;
  localparam int ITEMS_PER_PASS = 50;

  // One expected pin write, in the order the block must emit it.
  typedef struct {
    twbf_pkg::pin_e  pin;
    logic            level;
    twbf_pkg::wait_t wait_us;
    logic            last;
  } pin_write_exp_t;

  // Hand-typed facts about the end of a frame. They are only checked when
  // typed is set.
  typedef struct {
    bit             typed;
    int             len;
    twbf_pkg::pin_e pin;
    logic           level;
  } frame_end_t;

  typedef struct {
    logic [twbf_pkg::DATA_W-1:0] data;
    logic                        start;
    logic                        stop;
    frame_end_t                  fin;
  } request_t;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  logic [twbf_pkg::DATA_W-1:0]    in_data_byte;
  logic                           in_with_start;
  logic                           in_with_stop;
  logic                           out_valid;
  logic                           out_stall;
  logic                           out_pin_select;
  logic                           out_level;
  logic [twbf_pkg::WAIT_W-1:0]    out_wait_us;
  logic                           out_last;
  logic                           cfg_we;
  logic [twbf_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [twbf_pkg::WAIT_W-1:0]    cfg_data;

  two_wire_byte_write_framer_unit u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_with_start  (in_with_start),
    .in_with_stop   (in_with_stop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pin_select (out_pin_select),
    .out_level      (out_level),
    .out_wait_us    (out_wait_us),
    .out_last       (out_last),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // Shadow copies of the three wait registers, starting at their reset values.
  twbf_pkg::wait_t bit_phase_us = twbf_pkg::BIT_PHASE_RESET;
  twbf_pkg::wait_t edge_us      = twbf_pkg::EDGE_RESET;
  twbf_pkg::wait_t ack_low_us   = twbf_pkg::ACK_LOW_RESET;

  pin_write_exp_t pin_write_q[$];
  frame_end_t     frame_end_q[$];

  int errors       = 0;
  int run_len      = 0;
  int stall_left   = 0;
  bit recv_burst   = 1'b0;
  bit sender_burst = 1'b0;

  pin_write_exp_t want;
  frame_end_t     fin_want;

  // The edge cases. The first rows have a frame length and final write that
  // can be read straight off the sequence: 27 writes for a bare byte, three
  // more for a start and four more for a stop. Without a stop the frame ends
  // on the clock going low after the ack pulse. With a stop it ends on the
  // data line going high. The other rows rely on the model alone.
  request_t dir_rows[12] = '{
    '{8'h00, 1'b0, 1'b0, '{1'b1, 27, twbf_pkg::PIN_CLK, 1'b0}},
    '{8'hFF, 1'b1, 1'b1, '{1'b1, 34, twbf_pkg::PIN_DIO, 1'b1}},
    '{8'h01, 1'b1, 1'b0, '{1'b1, 30, twbf_pkg::PIN_CLK, 1'b0}},
    '{8'h80, 1'b0, 1'b1, '{1'b1, 31, twbf_pkg::PIN_DIO, 1'b1}},
    '{8'hA5, 1'b1, 1'b1, '{1'b0, 0, twbf_pkg::PIN_CLK, 1'b0}},
    '{8'h5A, 1'b0, 1'b0, '{1'b0, 0, twbf_pkg::PIN_CLK, 1'b0}},
    '{8'h0F, 1'b1, 1'b0, '{1'b0, 0, twbf_pkg::PIN_CLK, 1'b0}},
    '{8'hF0, 1'b0, 1'b1, '{1'b0, 0, twbf_pkg::PIN_CLK, 1'b0}},
    '{8'h55, 1'b1, 1'b1, '{1'b0, 0, twbf_pkg::PIN_CLK, 1'b0}},
    '{8'hAA, 1'b0, 1'b0, '{1'b0, 0, twbf_pkg::PIN_CLK, 1'b0}},
    '{8'hFE, 1'b0, 1'b0, '{1'b0, 0, twbf_pkg::PIN_CLK, 1'b0}},
    '{8'h7F, 1'b1, 1'b1, '{1'b0, 0, twbf_pkg::PIN_CLK, 1'b0}}
  };

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // A run that reaches three milliseconds of simulated time means the block
  // has hung. The slowest legal run is well under a millisecond.
  initial begin
    #3_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic void push_write(input twbf_pkg::pin_e pin, input logic level,
                                     input twbf_pkg::wait_t wt, input logic last);
    pin_write_exp_t w;
    w.pin     = pin;
    w.level   = level;
    w.wait_us = wt;
    w.last    = last;
    pin_write_q.push_back(w);
  endfunction

  // Queues the full run of pin writes for one request under the current
  // register values. The final write always carries a wait of zero.
  function automatic void frame_pin_writes(input logic [twbf_pkg::DATA_W-1:0] data_in,
                                           input logic start_in, input logic stop_in);
    int b;
    if (start_in) begin
      push_write(twbf_pkg::PIN_DIO, 1'b1, 4'd0, 1'b0);
      push_write(twbf_pkg::PIN_CLK, 1'b1, edge_us, 1'b0);
      push_write(twbf_pkg::PIN_DIO, 1'b0, edge_us, 1'b0);
    end
    // Least significant bit first; bits past the byte would go out as zero.
    for (b = 0; b < twbf_pkg::BITS_PER_WORD; b++) begin
      push_write(twbf_pkg::PIN_CLK, 1'b0, 4'd0, 1'b0);
      push_write(twbf_pkg::PIN_DIO, (b < twbf_pkg::DATA_W) ? data_in[b] : 1'b0,
                 bit_phase_us, 1'b0);
      push_write(twbf_pkg::PIN_CLK, 1'b1, bit_phase_us, 1'b0);
    end
    // The ack pulse is always sent. It closes the frame when no stop follows.
    push_write(twbf_pkg::PIN_CLK, 1'b0, ack_low_us, 1'b0);
    push_write(twbf_pkg::PIN_CLK, 1'b1, edge_us, 1'b0);
    push_write(twbf_pkg::PIN_CLK, 1'b0, 4'd0, !stop_in);
    if (stop_in) begin
      push_write(twbf_pkg::PIN_CLK, 1'b0, edge_us, 1'b0);
      push_write(twbf_pkg::PIN_DIO, 1'b0, edge_us, 1'b0);
      push_write(twbf_pkg::PIN_CLK, 1'b1, edge_us, 1'b0);
      push_write(twbf_pkg::PIN_DIO, 1'b1, 4'd0, 1'b1);
    end
  endfunction

  // Presents one request after a gap of idle cycles. The task returns at the
  // edge where the transaction is taken. With no gap, valid simply stays high
  // into the next request. The prediction is made at the accepting edge, so
  // the register values in force for that request are the ones used.
  task automatic send_request(input request_t r, input int gap);
    if (gap > 0) begin
      @(negedge clk);
      in_valid     <= 1'b0;
      in_data_byte <= twbf_pkg::DATA_W'($urandom_range(0, 255));
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    in_data_byte  <= r.data;
    in_with_start <= r.start;
    in_with_stop  <= r.stop;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    frame_pin_writes(r.data, r.start, r.stop);
    frame_end_q.push_back(r.fin);
  endtask

  // Lowers valid and holds the sender back until every expected pin write
  // has been taken. The extra cycles let the sequencer settle back to idle.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pin_write_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [twbf_pkg::CFG_IDX_W-1:0] idx,
                           input twbf_pkg::wait_t val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      twbf_pkg::REG_BIT_PHASE: bit_phase_us = val;
      twbf_pkg::REG_EDGE:      edge_us = val;
      twbf_pkg::REG_ACK_LOW:   ack_low_us = val;
      default: ;
    endcase
  endtask

  // Writes all three registers, then writes junk to the unused index, which
  // must leave them untouched.
  task automatic apply_settings(input twbf_pkg::wait_t bp, input twbf_pkg::wait_t ed,
                                input twbf_pkg::wait_t ak);
    write_reg(twbf_pkg::REG_BIT_PHASE, bp);
    write_reg(twbf_pkg::REG_EDGE, ed);
    write_reg(twbf_pkg::REG_ACK_LOW, ak);
    write_reg(REG_UNUSED, twbf_pkg::WAIT_W'($urandom_range(0, 15)));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // The receiver holds each pin write off for a drawn number of cycles. Now
  // and then it runs a whole frame with no stall at all.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Checks every accepted pin write against the oldest expected one.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pin_write_q.size() == 0) begin
        $display("%0t: unexpected pin write pin=%0d level=%0d wait=%0d last=%0d",
                 $time, out_pin_select, out_level, out_wait_us, out_last);
        errors++;
      end else begin
        want = pin_write_q.pop_front();
        if (out_pin_select !== want.pin) begin
          $display("%0t: pin_select expected %0d actual %0d", $time, want.pin,
                   out_pin_select);
          errors++;
        end
        if (out_level !== want.level) begin
          $display("%0t: level expected %0d actual %0d", $time, want.level, out_level);
          errors++;
        end
        if (out_wait_us !== want.wait_us) begin
          $display("%0t: wait_us expected %0d actual %0d", $time, want.wait_us,
                   out_wait_us);
          errors++;
        end
        if (out_last !== want.last) begin
          $display("%0t: last expected %0d actual %0d", $time, want.last, out_last);
          errors++;
        end
      end
      run_len++;
      if (out_last === 1'b1) begin
        // The typed table rows also pin down the frame length and the final write.
        if (frame_end_q.size() != 0) begin
          fin_want = frame_end_q.pop_front();
          if (fin_want.typed) begin
            if (run_len != fin_want.len) begin
              $display("%0t: frame length expected %0d actual %0d", $time, fin_want.len,
                       run_len);
              errors++;
            end
            if (out_pin_select !== fin_want.pin || out_level !== fin_want.level ||
                out_wait_us !== 4'd0) begin
              $display("%0t: final write expected %0d/%0d/0 actual %0d/%0d/%0d",
                       $time, fin_want.pin, fin_want.level, out_pin_select, out_level,
                       out_wait_us);
              errors++;
            end
          end
        end
        run_len = 0;
        recv_burst = ($urandom_range(0, 3) == 0);
      end
      stall_left = recv_burst ? 0 : $urandom_range(0, 11);
    end
  end

  initial begin
    request_t        r;
    twbf_pkg::wait_t bp;
    twbf_pkg::wait_t ed;
    twbf_pkg::wait_t ak;
    int              i;
    int              p;
    int              k;

    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_data_byte  <= '0;
    in_with_start <= 1'b0;
    in_with_stop  <= 1'b0;
    out_stall     <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // The edge-case table runs under the reset values of the wait registers.
    for (i = 0; i < 12; i++) begin
      send_request(dir_rows[i], $urandom_range(0, 11));
    end
    wait_idle();

    // Random requests under each setting: all zero, all fifteen, two mixed
    // extremes, then two fully random settings. The drain between passes also
    // holds the sender until every pin write has come out.
    for (p = 0; p < NUM_SETTINGS; p++) begin
      case (p)
        0: begin bp = 4'd0;  ed = 4'd0;  ak = 4'd0;  end
        1: begin bp = 4'd15; ed = 4'd15; ak = 4'd15; end
        2: begin bp = 4'd0;  ed = 4'd15; ak = 4'd0;  end
        3: begin bp = 4'd15; ed = 4'd0;  ak = 4'd15; end
        default: begin
          bp = twbf_pkg::WAIT_W'($urandom_range(0, 15));
          ed = twbf_pkg::WAIT_W'($urandom_range(0, 15));
          ak = twbf_pkg::WAIT_W'($urandom_range(0, 15));
        end
      endcase
      apply_settings(bp, ed, ak);
      for (k = 0; k < ITEMS_PER_PASS; k++) begin
        // Every ten requests, decide whether the next stretch goes back to back.
        if (k % 10 == 0) begin
          sender_burst = ($urandom_range(0, 3) == 0);
        end
        r.data  = twbf_pkg::DATA_W'($urandom_range(0, 255));
        r.start = 1'($urandom_range(0, 1));
        r.stop  = 1'($urandom_range(0, 1));
        r.fin   = '{1'b0, 0, twbf_pkg::PIN_CLK, 1'b0};
        send_request(r, sender_burst ? 0 : $urandom_range(0, 11));
      end
      wait_idle();
    end

    // Any stray pin write after the last frame would show up in this window.
    repeat (40) @(posedge clk);
    if (pin_write_q.size() != 0) begin
      $display("%0t: %0d expected pin writes never arrived", $time, pin_write_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
